### src/ppu_pkg.sv
`default_nettype none
package ppu_pkg;

    typedef enum logic [1:0] {
        CMD_PALETTE = 2'd0,
        CMD_PIXEL   = 2'd1,
        CMD_FRAME   = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_SRC_STRIDE = 2'd2
    } t_reg_index;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 10;
    localparam int unsigned POS_W = 10;

    localparam logic [POS_W-1:0] RST_SRC_WIDTH  = 10'd256;
    localparam logic [POS_W-1:0] RST_SRC_HEIGHT = 10'd240;
    localparam logic [POS_W-1:0] RST_SRC_STRIDE = 10'd256;
    localparam logic [POS_W-1:0] ROW_MAX        = 10'd1023;

endpackage
`default_nettype wire

### src/ppu_if.sv
`default_nettype none
interface ppu_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ppu_pkg::CFG_IDX_W-1:0]   index;
    logic [ppu_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface ppu_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [7:0]  entry_index;
    logic [15:0] entry_color;
    logic [7:0]  pixel_byte;

    modport source (output valid, cmd, entry_index, entry_color, pixel_byte, input ready);
    modport sink   (input valid, cmd, entry_index, entry_color, pixel_byte, output ready);
endinterface

interface ppu_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] fb_address;
    logic [15:0] pixel_color;
    logic        run_last;

    modport source (output valid, fb_address, pixel_color, run_last, input ready);
    modport sink   (input valid, fb_address, pixel_color, run_last, output ready);
endinterface
`default_nettype wire

### src/ppu_ram.sv
`default_nettype none
module ppu_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### src/palette_pixel_upscaler.sv
// A taken pixel is registered with its palette read, then moved into the burst
// register. Throughput: one output word per cycle while the sink is ready, through a
// single write port; a pixel gives up to 4 words (4 with both doublings), others none.
// Palette lookup uses one registered RAM read, then a 4-slot burst register drains.
// Reset (synchronous, active low) clears positions and valids and loads the config
// registers with their defaults; palette contents are undefined until written.
`default_nettype none
module palette_pixel_upscaler #(
    parameter int unsigned FB_WIDTH  = 256,
    parameter int unsigned FB_HEIGHT = 240
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ppu_cfg_if.sink    i_cfg,
    ppu_in_if.sink     i_pix,
    ppu_out_if.source  o_wr
);

    localparam int unsigned PW = ppu_pkg::POS_W;
    localparam logic [11:0] FBW = 12'(FB_WIDTH);
    localparam logic [11:0] FBH = 12'(FB_HEIGHT);

    // configuration
    logic [PW-1:0] r_width, r_height, r_stride;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= ppu_pkg::RST_SRC_WIDTH;
            r_height <= ppu_pkg::RST_SRC_HEIGHT;
            r_stride <= ppu_pkg::RST_SRC_STRIDE;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                ppu_pkg::REG_SRC_WIDTH:  r_width  <= i_cfg.data;
                ppu_pkg::REG_SRC_HEIGHT: r_height <= i_cfg.data;
                ppu_pkg::REG_SRC_STRIDE: r_stride <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // pipeline handshake
    logic        r_s1_valid;
    logic [10:0] r_s1_row;
    logic [10:0] r_s1_col;
    logic [3:0]  r_s1_mask;
    logic        r_b_valid;
    logic [3:0]  r_b_mask;
    logic [15:0] r_b_color;
    logic [15:0] r_b_addr [4];

    logic out_take, b_last, buf_free, s1_move, in_take;
    logic is_pix, is_pal, is_frame;

    assign b_last   = ((r_b_mask & (r_b_mask - 4'd1)) == 4'd0);
    assign out_take = r_b_valid && o_wr.ready;
    assign buf_free = !r_b_valid || (out_take && b_last);
    assign s1_move  = r_s1_valid && buf_free;
    assign i_pix.ready = !r_s1_valid || buf_free;
    assign in_take  = i_pix.valid && i_pix.ready;

    assign is_pix   = (i_pix.cmd == ppu_pkg::CMD_PIXEL);
    assign is_pal   = (i_pix.cmd == ppu_pkg::CMD_PALETTE);
    assign is_frame = (i_pix.cmd == ppu_pkg::CMD_FRAME);

    // position tracking
    logic [PW-1:0] r_col, r_row;
    logic [PW-1:0] eff;
    logic          wrap;

    assign eff  = (r_stride < r_width) ? r_width : r_stride;
    assign wrap = ({1'b0, r_col} + 11'd1) >= {1'b0, eff};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_take) begin
            if (is_frame) begin
                r_col <= '0;
                r_row <= '0;
            end else if (is_pix) begin
                if (wrap) begin
                    r_col <= '0;
                    if (r_row < ppu_pkg::ROW_MAX) begin
                        r_row <= r_row + 10'd1;
                    end
                end else begin
                    r_col <= r_col + 10'd1;
                end
            end
        end
    end

    // write plan for the current pixel
    logic        dbl_w, fits, dbl_h, in_range, active, row0_ok, row1_ok;
    logic [10:0] n_row0, n_col0;
    logic [11:0] center;
    logic [3:0]  n_mask;

    assign dbl_w    = {1'b0, r_width, 1'b0} <= FBW;
    assign fits     = {2'b00, r_width} <= FBW;
    assign dbl_h    = {1'b0, r_height, 1'b0} <= FBH;
    assign in_range = (r_col < r_width) && (r_row < r_height);
    assign active   = in_range && (dbl_w || fits);
    assign n_row0   = dbl_h ? {r_row, 1'b0} : {1'b0, r_row};
    assign row0_ok  = {1'b0, n_row0} < FBH;
    assign row1_ok  = ({1'b0, n_row0} + 12'd1) < FBH;
    assign center   = ((FBW - {2'b00, r_width}) >> 1) + {2'b00, r_col};
    assign n_col0   = dbl_w ? {r_col, 1'b0} : center[10:0];
    assign n_mask   = {active & dbl_w & dbl_h & row1_ok,
                       active & dbl_h & row1_ok,
                       active & dbl_w & row0_ok,
                       active & row0_ok};

    logic s1_load;
    assign s1_load = in_take && is_pix && (n_mask != 4'd0);

    logic [15:0] pal_rdata;

    ppu_ram #(
        .WIDTH(16),
        .DEPTH(256)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (in_take && is_pal),
        .i_waddr (i_pix.entry_index),
        .i_wdata (i_pix.entry_color),
        .i_re    (s1_load),
        .i_raddr (i_pix.pixel_byte),
        .o_rdata (pal_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_load) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_row  <= n_row0;
            r_s1_col  <= n_col0;
            r_s1_mask <= n_mask;
        end
    end

    // burst register: up to four words, lowest slot first
    logic [22:0] base0;
    assign base0 = 23'(r_s1_row) * 23'(FB_WIDTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (buf_free) begin
            r_b_valid <= s1_move;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_b_mask  <= r_s1_mask;
            r_b_color <= pal_rdata;
            for (int k = 0; k < 4; k++) begin
                r_b_addr[k] <= 16'(base0 + (k[1] ? 23'(FB_WIDTH) : 23'd0)
                                         + 23'(r_s1_col) + 23'(k[0]));
            end
        end else if (out_take) begin
            r_b_mask <= r_b_mask & (r_b_mask - 4'd1);
        end
    end

    logic [1:0] sel;
    always_comb begin
        if (r_b_mask[0]) begin
            sel = 2'd0;
        end else if (r_b_mask[1]) begin
            sel = 2'd1;
        end else if (r_b_mask[2]) begin
            sel = 2'd2;
        end else begin
            sel = 2'd3;
        end
    end

    assign o_wr.valid       = r_b_valid;
    assign o_wr.fb_address  = r_b_addr[sel];
    assign o_wr.pixel_color = r_b_color;
    assign o_wr.run_last    = b_last;

endmodule
`default_nettype wire
